// File: rtl/bitic_pkg.sv
// package: shared types and constants for the interrupt, timer and i/o register block
`timescale 1ns / 1ps
`default_nettype none
package bitic_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_LINE  = 2'd3
  } req_type_e;

  localparam logic [1:0] LINE_VIDEO  = 2'd0;
  localparam logic [1:0] LINE_FLOPPY = 2'd1;
  localparam logic [1:0] LINE_SCSI   = 2'd2;

  localparam int unsigned IoDepth = 32;
  localparam int unsigned IoAddrW = 5;

  localparam logic [31:0] REGION_MASK = 32'h07c0_0000;
  localparam logic [31:0] IO_REGION   = 32'h0200_0000;
  localparam logic [31:0] INTC_MASK   = 32'h0700_0000;
  localparam logic [31:0] INTC_REGION = 32'h0100_0000;

  // interrupt control select: address bits 23, 22, 0
  localparam logic [2:0] INTC_ENABLE  = 3'b001;
  localparam logic [2:0] INTC_PENDING = 3'b011;
  localparam logic [2:0] INTC_SET     = 3'b101;

  localparam logic [IoAddrW-1:0] IO_CTRL     = 5'h01;
  localparam logic [IoAddrW-1:0] IO_SYS_ST   = 5'h03;
  localparam logic [IoAddrW-1:0] IO_TIMER_ST = 5'h07;
  localparam logic [IoAddrW-1:0] IO_REV      = 5'h09;
  localparam logic [IoAddrW-1:0] IO_CNT_HI   = 5'h0b;
  localparam logic [IoAddrW-1:0] IO_CNT_LO   = 5'h0d;
  localparam logic [IoAddrW-1:0] IO_ST_CLR   = 5'h17;
  localparam logic [IoAddrW-1:0] IO_TO_CLR   = 5'h19;

  localparam logic [7:0]  REV_VALUE = 8'h04;
  localparam logic [15:0] WRAP_LOW  = 16'h1000;
  localparam logic [15:0] WRAP_HIGH = 16'hf000;

  localparam int unsigned IrqW = 14;

  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] address;
    logic [7:0]  write_data;
    logic [1:0]  line_id;
    logic        line_level;
  } item_t;

  typedef struct packed {
    logic [7:0]      read_data;
    logic [IrqW-1:0] irq_request;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/bitic_core.sv
// state registers, bus decode and request mask for one transaction
`timescale 1ns / 1ps
`default_nettype none
module bitic_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire bitic_pkg::item_t  item_i,
  output bitic_pkg::result_t     result_o
);

  logic [3:0]  int_enable_q, int_enable_d;
  logic [3:0]  int_pending_q, int_pending_d;
  logic [7:0]  io_q [bitic_pkg::IoDepth];
  logic [7:0]  io_d [bitic_pkg::IoDepth];
  logic [15:0] countdown_q, countdown_d;
  logic [15:0] count_latch_q, count_latch_d;
  logic        latch_valid_q, latch_valid_d;
  logic        video_q, video_d;
  logic        floppy_q, floppy_d;

  logic                          timeout;
  logic                          io_hit;
  logic                          intc_hit;
  logic [2:0]                    intc_sel;
  logic [bitic_pkg::IoAddrW-1:0] reg_idx;
  logic [15:0]                   timer_view;
  logic [15:0]                   count_dec;
  logic [7:0]                    rd;
  logic [3:0]                    active;
  logic [bitic_pkg::IrqW-1:0]    irq;

  assign timeout    = |item_i.address[31:29];
  assign io_hit     = (item_i.address & bitic_pkg::REGION_MASK) == bitic_pkg::IO_REGION;
  assign intc_hit   = (item_i.address & bitic_pkg::INTC_MASK) == bitic_pkg::INTC_REGION;
  assign intc_sel   = {item_i.address[23], item_i.address[22], item_i.address[0]};
  assign reg_idx    = item_i.address[bitic_pkg::IoAddrW-1:0];
  assign timer_view = latch_valid_q ? count_latch_q : countdown_q;
  assign count_dec  = countdown_q - 16'd1;

  always_comb begin
    int_enable_d  = int_enable_q;
    int_pending_d = int_pending_q;
    io_d          = io_q;
    countdown_d   = countdown_q;
    count_latch_d = count_latch_q;
    latch_valid_d = latch_valid_q;
    video_d       = video_q;
    floppy_d      = floppy_q;
    rd            = 8'h00;
    unique case (item_i.req_type)
      bitic_pkg::REQ_READ: begin
        if (timeout) begin
          io_d[bitic_pkg::IO_SYS_ST][5] = 1'b1;
        end else if (io_hit) begin
          unique case (reg_idx)
            bitic_pkg::IO_REV: begin
              count_latch_d = countdown_q;
              latch_valid_d = 1'b1;
              rd            = bitic_pkg::REV_VALUE;
            end
            bitic_pkg::IO_CNT_HI: rd = timer_view[15:8];
            bitic_pkg::IO_CNT_LO: begin
              latch_valid_d = 1'b0;
              rd            = timer_view[7:0];
            end
            default: rd = io_q[reg_idx];
          endcase
        end else if (intc_hit) begin
          unique case (intc_sel)
            bitic_pkg::INTC_ENABLE:  rd = {4'h0, int_enable_q};
            bitic_pkg::INTC_PENDING: rd = {4'h0, int_pending_q};
            default:                 rd = 8'h00;
          endcase
        end
      end
      bitic_pkg::REQ_WRITE: begin
        if (timeout) begin
          io_d[bitic_pkg::IO_SYS_ST][5] = 1'b1;
        end else if (io_hit) begin
          if (reg_idx != bitic_pkg::IO_SYS_ST) begin
            io_d[reg_idx] = item_i.write_data;
          end
          unique case (reg_idx)
            bitic_pkg::IO_REV:    io_d[bitic_pkg::IO_TIMER_ST][5] = 1'b0;
            bitic_pkg::IO_CNT_HI: countdown_d[15:8] = item_i.write_data;
            bitic_pkg::IO_CNT_LO: countdown_d[7:0] = item_i.write_data;
            bitic_pkg::IO_ST_CLR: io_d[bitic_pkg::IO_SYS_ST][3:2] = 2'b00;
            bitic_pkg::IO_TO_CLR: io_d[bitic_pkg::IO_SYS_ST][5] = 1'b0;
            default: ;
          endcase
        end else if (intc_hit) begin
          unique case (intc_sel)
            bitic_pkg::INTC_ENABLE:  int_enable_d = item_i.write_data[3:0];
            bitic_pkg::INTC_PENDING: int_pending_d = item_i.write_data[3:0];
            bitic_pkg::INTC_SET:     int_pending_d = int_pending_q | item_i.write_data[3:0];
            default: ;
          endcase
        end
      end
      bitic_pkg::REQ_TICK: begin
        countdown_d = count_dec;
        if ((count_dec > bitic_pkg::WRAP_HIGH && countdown_q < bitic_pkg::WRAP_LOW) ||
            (count_dec < bitic_pkg::WRAP_LOW && countdown_q > bitic_pkg::WRAP_HIGH)) begin
          io_d[bitic_pkg::IO_TIMER_ST][5] = 1'b1;
        end
      end
      bitic_pkg::REQ_LINE: begin
        unique case (item_i.line_id)
          bitic_pkg::LINE_VIDEO:  video_d = item_i.line_level;
          bitic_pkg::LINE_FLOPPY: floppy_d = item_i.line_level;
          bitic_pkg::LINE_SCSI:   int_pending_d[1] = item_i.line_level;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // request mask from the state as left by this transaction
  always_comb begin
    active = int_enable_d & int_pending_d;
    irq    = '0;
    irq[0] = active[0]
           | (io_d[bitic_pkg::IO_TIMER_ST][4] & io_d[bitic_pkg::IO_TIMER_ST][5])
           | (io_d[bitic_pkg::IO_SYS_ST][3] & io_d[bitic_pkg::IO_CTRL][5]);
    irq[7]  = active[1];
    irq[3]  = active[2];
    irq[13] = active[3];
    irq[4]  = video_d;
    irq[12] = floppy_d & io_d[bitic_pkg::IO_CTRL][0];
    if (!int_enable_d[0]) begin
      irq = '0;
    end
  end

  assign result_o.read_data   = rd;
  assign result_o.irq_request = irq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_enable_q  <= '0;
      int_pending_q <= '0;
      countdown_q   <= '0;
      count_latch_q <= '0;
      latch_valid_q <= 1'b0;
      video_q       <= 1'b0;
      floppy_q      <= 1'b0;
      for (int i = 0; i < bitic_pkg::IoDepth; i++) begin
        io_q[i] <= 8'h00;
      end
    end else if (step_i) begin
      int_enable_q  <= int_enable_d;
      int_pending_q <= int_pending_d;
      countdown_q   <= countdown_d;
      count_latch_q <= count_latch_d;
      latch_valid_q <= latch_valid_d;
      video_q       <= video_d;
      floppy_q      <= floppy_d;
      io_q          <= io_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/board_interrupt_timer_io_controller_top.sv
// top level: input register, register block core and result register
//
//   channel | direction | handshake                | payload
//   in      | sink      | in_valid_i / in_ready_o  | req_type, address, write_data,
//           |           |                          | line_id, line_level
//   out     | source    | out_valid_o / out_ready_i| read_data, irq_request
//
// one transaction per clock sustained while the result register is not stalled
// state is updated as a transaction moves from the input register to the result register
// reset clears all register block state, including the 32 i/o bytes, at once
// a stalled result holds in the result register while one more transaction waits behind it
`timescale 1ns / 1ps
`default_nettype none
module board_interrupt_timer_io_controller_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [1:0]  line_id_i,
  input  wire logic        line_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic [13:0]      irq_request_o
);

  logic                s1_valid_q, s1_valid_d;
  bitic_pkg::item_t    item_q;
  logic                out_valid_q, out_valid_d;
  bitic_pkg::result_t  res_q;
  bitic_pkg::result_t  res_d;
  logic                advance;
  logic                in_fire;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.req_type   <= bitic_pkg::req_type_e'(req_type_i);
      item_q.address    <= address_i;
      item_q.write_data <= write_data_i;
      item_q.line_id    <= line_id_i;
      item_q.line_level <= line_level_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  bitic_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = res_q.read_data;
  assign irq_request_o = res_q.irq_request;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("transaction moved on but no result shown");

  a_irq_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((irq_request_o & 14'h0f66) == 14'h0000))
    else $error("unused request bits set");

  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.req_type != bitic_pkg::REQ_READ) |=> (read_data_o == 8'h00))
    else $error("read data not zero for a non-read transaction");

endmodule
`default_nettype wire
